FILE: sv/mmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmu_pkg;

    localparam int MAX_DIM_DEF      = 8;
    localparam int ELEMENT_BITS_DEF = 16;
    localparam int DIM_W            = 4;
    localparam int POS_W            = 3;
    localparam int PRODUCT_W        = 36;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_B     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_C     = 2'd2;

    typedef struct packed {
        logic             first;
        logic             last_term;
        logic             final_entry;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
    } tag_t;

endpackage

`default_nettype wire

FILE: sv/mmu_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module mmu_mac #(
    parameter int MAX_DIM      = mmu_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_BITS = mmu_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_b,
    input  wire logic                               wr_c,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    input  wire logic [ELEMENT_BITS-1:0]            wr_data,
    input  wire logic                               issue_valid,
    input  wire mmu_pkg::tag_t                      issue_tag,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_b_addr,
    input  wire logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_c_addr,
    output logic                                    advance,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [mmu_pkg::PRODUCT_W-1:0]    product,
    output logic [mmu_pkg::POS_W-1:0]               row,
    output logic [mmu_pkg::POS_W-1:0]               column,
    output logic                                    last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEMENT_BITS-1:0] left_store [DEPTH];
    logic [ELEMENT_BITS-1:0] right_store [DEPTH];

    logic                               s1_valid_reg;
    mmu_pkg::tag_t                      s1_tag_reg;
    logic signed [ELEMENT_BITS-1:0]     b_rd_reg;
    logic signed [ELEMENT_BITS-1:0]     c_rd_reg;
    logic                               s2_valid_reg;
    mmu_pkg::tag_t                      s2_tag_reg;
    logic signed [2*ELEMENT_BITS-1:0]   prod_reg;
    logic [mmu_pkg::PRODUCT_W-1:0]      acc_reg;
    logic [mmu_pkg::PRODUCT_W-1:0]      acc_next;
    logic                               out_valid_reg;
    logic [mmu_pkg::PRODUCT_W-1:0]      product_reg;
    logic [mmu_pkg::POS_W-1:0]          row_reg;
    logic [mmu_pkg::POS_W-1:0]          column_reg;
    logic                               last_reg;

    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        acc_next = (s2_tag_reg.first ? '0 : acc_reg)
                 + mmu_pkg::PRODUCT_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            left_store[wr_addr] <= wr_data;
        end
        if (wr_c)
        begin
            right_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_rd_reg   <= left_store[rd_b_addr];
            c_rd_reg   <= right_store[rd_c_addr];
            s1_tag_reg <= issue_tag;
            prod_reg   <= b_rd_reg * c_rd_reg;
            s2_tag_reg <= s1_tag_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
            if (s2_valid_reg && s2_tag_reg.last_term)
            begin
                product_reg <= acc_next;
                row_reg     <= s2_tag_reg.row;
                column_reg  <= s2_tag_reg.column;
                last_reg    <= s2_tag_reg.final_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= issue_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_tag_reg.last_term;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign row       = row_reg;
    assign column    = column_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: sv/matrix_multiply_unit.sv
// Matrix product A = B * C over signed fixed-point elements.
// The input channel (in_valid, in_ready, element) takes one element per item:
// all of B in column-major order, then all of C in column-major order.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// rows_b, inner_size and cols_c; zero acts as one and values above MAX_DIM
// act as MAX_DIM. Any write to one of these registers drops a partial load.
// The output channel (out_valid, out_ready) carries product, row, column and
// last, one entry of A per item in column-major order, last on the final one.
// Elements are taken only while loading. After the last element of C, a
// single multiply-accumulate unit fed from two element stores does one product
// per cycle while the receiver does not stall. Each term passes the store read,
// product and accumulate registers, and each entry of A the output register.
// The next load is accepted as soon as the final product has been read from
// the stores.
// Reset sets all three dimensions to eight and empties the load; the element
// stores hold no defined values until written. When the receiver stalls, the
// output register holds its entry and the whole multiply pipeline freezes.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_unit #(
    parameter int MAX_DIM      = mmu_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_BITS = mmu_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mmu_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mmu_pkg::DIM_W-1:0]            cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [ELEMENT_BITS-1:0]       element,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [mmu_pkg::PRODUCT_W-1:0]      product,
    output logic [mmu_pkg::POS_W-1:0]                 row,
    output logic [mmu_pkg::POS_W-1:0]                 column,
    output logic                                      last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(2 * DEPTH + 1);
    localparam logic [mmu_pkg::DIM_W-1:0] MAX_DIM_V = mmu_pkg::DIM_W'(MAX_DIM);

    typedef enum logic {
        S_LOAD,
        S_RUN
    } state_t;

    function automatic logic [mmu_pkg::DIM_W-1:0] dim_of(input logic [mmu_pkg::DIM_W-1:0] v);
        logic [mmu_pkg::DIM_W-1:0] d;
        if (v == '0)
        begin
            d = mmu_pkg::DIM_W'(1);
        end
        else if (v > MAX_DIM_V)
        begin
            d = MAX_DIM_V;
        end
        else
        begin
            d = v;
        end
        return d;
    endfunction

    state_t                     state_reg, state_next;
    logic [mmu_pkg::DIM_W-1:0]  rows_b_reg, rows_b_next;
    logic [mmu_pkg::DIM_W-1:0]  inner_size_reg, inner_size_next;
    logic [mmu_pkg::DIM_W-1:0]  cols_c_reg, cols_c_next;
    logic [LCW-1:0]             load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic [AW-1:0]              b_addr_reg, b_addr_next;
    logic [AW-1:0]              c_addr_reg, c_addr_next;
    logic [AW-1:0]              c_base_reg, c_base_next;

    logic [mmu_pkg::DIM_W-1:0]  nr, nk, nc;
    logic [LCW-1:0]             nb, total;
    logic                       cfg_clear;
    logic                       in_accept;
    logic                       in_b_part;
    logic                       wr_b, wr_c;
    logic [AW-1:0]              wr_addr;
    logic                       advance;
    logic                       issue_valid;
    mmu_pkg::tag_t              issue_tag;
    logic                       k_last, i_last, j_last;

    assign nr    = dim_of(rows_b_reg);
    assign nk    = dim_of(inner_size_reg);
    assign nc    = dim_of(cols_c_reg);
    assign nb    = LCW'(nr) * LCW'(nk);
    assign total = nb + LCW'(nk) * LCW'(nc);

    assign cfg_ready = 1'b1;
    assign cfg_clear = cfg_valid && (cfg_index == mmu_pkg::REG_ROWS_B
                                  || cfg_index == mmu_pkg::REG_INNER_SIZE
                                  || cfg_index == mmu_pkg::REG_COLS_C);

    assign in_ready  = (state_reg == S_LOAD);
    assign in_accept = in_valid && in_ready;
    assign in_b_part = (load_cnt_reg < nb);
    assign wr_b      = in_accept && in_b_part;
    assign wr_c      = in_accept && !in_b_part;
    assign wr_addr   = in_b_part ? AW'(load_cnt_reg) : AW'(load_cnt_reg - nb);

    assign k_last = (mmu_pkg::DIM_W'(k_reg) == nk - mmu_pkg::DIM_W'(1));
    assign i_last = (mmu_pkg::DIM_W'(i_reg) == nr - mmu_pkg::DIM_W'(1));
    assign j_last = (mmu_pkg::DIM_W'(j_reg) == nc - mmu_pkg::DIM_W'(1));

    assign issue_valid           = (state_reg == S_RUN);
    assign issue_tag.first       = (k_reg == '0);
    assign issue_tag.last_term   = k_last;
    assign issue_tag.final_entry = k_last && i_last && j_last;
    assign issue_tag.row         = mmu_pkg::POS_W'(i_reg);
    assign issue_tag.column      = mmu_pkg::POS_W'(j_reg);

    always_comb
    begin
        state_next      = state_reg;
        rows_b_next     = rows_b_reg;
        inner_size_next = inner_size_reg;
        cols_c_next     = cols_c_reg;
        load_cnt_next   = load_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        b_addr_next     = b_addr_reg;
        c_addr_next     = c_addr_reg;
        c_base_next     = c_base_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                mmu_pkg::REG_ROWS_B:     rows_b_next     = cfg_data;
                mmu_pkg::REG_INNER_SIZE: inner_size_next = cfg_data;
                mmu_pkg::REG_COLS_C:     cols_c_next     = cfg_data;
                default:                 ;
            endcase
        end

        case (state_reg)
            S_LOAD:
            begin
                if (cfg_clear)
                begin
                    load_cnt_next = '0;
                end
                else if (in_accept)
                begin
                    if (load_cnt_reg + LCW'(1) == total)
                    begin
                        load_cnt_next = '0;
                        state_next    = S_RUN;
                        i_next        = '0;
                        j_next        = '0;
                        k_next        = '0;
                        b_addr_next   = '0;
                        c_addr_next   = '0;
                        c_base_next   = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + LCW'(1);
                    end
                end
            end
            S_RUN:
            begin
                if (advance)
                begin
                    if (!k_last)
                    begin
                        k_next      = k_reg + IDX_W'(1);
                        b_addr_next = b_addr_reg + AW'(nr);
                        c_addr_next = c_addr_reg + AW'(1);
                    end
                    else
                    begin
                        k_next = '0;
                        if (!i_last)
                        begin
                            i_next      = i_reg + IDX_W'(1);
                            b_addr_next = AW'(i_reg) + AW'(1);
                            c_addr_next = c_base_reg;
                        end
                        else
                        begin
                            i_next      = '0;
                            b_addr_next = '0;
                            if (!j_last)
                            begin
                                j_next      = j_reg + IDX_W'(1);
                                c_base_next = c_base_reg + AW'(nk);
                                c_addr_next = c_base_reg + AW'(nk);
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            rows_b_reg     <= mmu_pkg::DIM_W'(8);
            inner_size_reg <= mmu_pkg::DIM_W'(8);
            cols_c_reg     <= mmu_pkg::DIM_W'(8);
            load_cnt_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            b_addr_reg     <= '0;
            c_addr_reg     <= '0;
            c_base_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rows_b_reg     <= rows_b_next;
            inner_size_reg <= inner_size_next;
            cols_c_reg     <= cols_c_next;
            load_cnt_reg   <= load_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            b_addr_reg     <= b_addr_next;
            c_addr_reg     <= c_addr_next;
            c_base_reg     <= c_base_next;
        end
    end

    mmu_mac #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_b        (wr_b),
        .wr_c        (wr_c),
        .wr_addr     (wr_addr),
        .wr_data     (element),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .rd_b_addr   (b_addr_reg),
        .rd_c_addr   (c_addr_reg),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .product     (product),
        .row         (row),
        .column      (column),
        .last        (last)
    );

    // A partial load never reaches the element count of a full load.
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (load_cnt_reg < total))
        else $error("load count reached the full matrix size while loading");

    // The item that completes C starts the multiply sequence.
    a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !cfg_clear && (load_cnt_reg + LCW'(1) == total))
        |=> (state_reg == S_RUN))
        else $error("complete load did not start the multiply sequence");

    // Issuing the final product term ends the sequence.
    a_run_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_valid && advance && issue_tag.final_entry) |=> (state_reg == S_LOAD))
        else $error("sequencer did not return to loading after the final term");

endmodule

`default_nettype wire
